// ----- sv/pof_pkg.sv -----
// shared types, constants and the control store of the operand fetch unit
package pof_pkg;

  // memory size in bytes (power of two) and derived address widths
  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int BANK_AW   = MEM_AW - 1;

  // request codes
  localparam logic [1:0] OP_WRITE_REG = 2'd0;
  localparam logic [1:0] OP_WRITE_MEM = 2'd1;
  localparam logic [1:0] OP_RESOLVE   = 2'd2;

  // register numbers with a fixed role
  localparam logic [2:0] REG_SP = 3'd6;
  localparam logic [2:0] REG_PC = 3'd7;

  // microprogram counter width
  localparam int UPC_W = 5;

  // temp register source
  typedef enum logic [1:0] {
    T_HOLD,
    T_REG,
    T_ALU,
    T_MEM
  } t_src_t;

  // which register the datapath reads and writes
  typedef enum logic {
    SEL_R,
    SEL_PC
  } reg_sel_t;

  // second adder operand
  typedef enum logic [2:0] {
    ALU_ADD_STEP,
    ALU_SUB_STEP,
    ALU_ADD_TWO,
    ALU_SUB_TWO,
    ALU_ADD_REG
  } alu_b_t;

  // effective address register source
  typedef enum logic [1:0] {
    EA_HOLD,
    EA_T,
    EA_RIDX,
    EA_ZERO
  } ea_src_t;

  // result value source, used by the final word of a program
  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_MEM,
    VAL_REG
  } val_src_t;

  // sequencing
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_DISPATCH,
    SEQ_DONE
  } seq_t;

  // one control word
  typedef struct packed {
    t_src_t   t_src;
    reg_sel_t reg_sel;
    alu_b_t   alu_b;
    logic     rf_we;
    ea_src_t  ea_src;
    val_src_t val_src;
    logic     byte_by_step;
    logic     status;
    seq_t     seq;
  } ctrl_t;

  localparam ctrl_t CW_NOP = '{
    t_src:        T_HOLD,
    reg_sel:      SEL_R,
    alu_b:        ALU_ADD_STEP,
    rf_we:        1'b0,
    ea_src:       EA_HOLD,
    val_src:      VAL_ZERO,
    byte_by_step: 1'b0,
    status:       1'b0,
    seq:          SEQ_NEXT
  };

  // program entry points
  localparam logic [UPC_W-1:0] UA_DISPATCH = 5'd0;
  localparam logic [UPC_W-1:0] UA_M0 = 5'd1;
  localparam logic [UPC_W-1:0] UA_M1 = 5'd2;
  localparam logic [UPC_W-1:0] UA_M2 = 5'd5;
  localparam logic [UPC_W-1:0] UA_M3 = 5'd8;
  localparam logic [UPC_W-1:0] UA_M4 = 5'd13;
  localparam logic [UPC_W-1:0] UA_M5 = 5'd17;
  localparam logic [UPC_W-1:0] UA_M6 = 5'd23;
  localparam logic [UPC_W-1:0] UA_M7 = 5'd29;

  // dispatch table: addressing mode to program start
  function automatic logic [UPC_W-1:0] ucode_entry(logic [2:0] mode);
    logic [UPC_W-1:0] a;
    unique case (mode)
      3'd0:    a = UA_M0;
      3'd1:    a = UA_M1;
      3'd2:    a = UA_M2;
      3'd3:    a = UA_M3;
      3'd4:    a = UA_M4;
      3'd5:    a = UA_M5;
      3'd6:    a = UA_M6;
      default: a = UA_M7;
    endcase
    return a;
  endfunction

  // control store; memory read data always reflects temp of the previous step
  function automatic ctrl_t ucode(logic [UPC_W-1:0] upc);
    ctrl_t c;
    c = CW_NOP;
    unique case (upc)
      UA_DISPATCH: c.seq = SEQ_DISPATCH;
      // register
      UA_M0: begin
        c.ea_src = EA_RIDX; c.val_src = VAL_REG; c.seq = SEQ_DONE;
      end
      // deferred
      UA_M1: c.t_src = T_REG;
      UA_M1 + 5'd1: c.ea_src = EA_T;
      UA_M1 + 5'd2: begin
        c.val_src = VAL_MEM; c.seq = SEQ_DONE;
      end
      // autoincrement
      UA_M2: c.t_src = T_REG;
      UA_M2 + 5'd1: begin
        c.ea_src = EA_T; c.alu_b = ALU_ADD_STEP; c.rf_we = 1'b1;
      end
      UA_M2 + 5'd2: begin
        c.val_src = VAL_MEM; c.byte_by_step = 1'b1; c.seq = SEQ_DONE;
      end
      // autoincrement deferred
      UA_M3: c.t_src = T_REG;
      UA_M3 + 5'd1: begin
        c.alu_b = ALU_ADD_TWO; c.rf_we = 1'b1;
      end
      UA_M3 + 5'd2: c.t_src = T_MEM;
      UA_M3 + 5'd3: c.ea_src = EA_T;
      UA_M3 + 5'd4: begin
        c.val_src = VAL_MEM; c.seq = SEQ_DONE;
      end
      // autodecrement
      UA_M4: c.t_src = T_REG;
      UA_M4 + 5'd1: begin
        c.t_src = T_ALU; c.alu_b = ALU_SUB_STEP; c.rf_we = 1'b1;
      end
      UA_M4 + 5'd2: c.ea_src = EA_T;
      UA_M4 + 5'd3: begin
        c.val_src = VAL_MEM; c.byte_by_step = 1'b1; c.seq = SEQ_DONE;
      end
      // autodecrement deferred
      UA_M5: c.t_src = T_REG;
      UA_M5 + 5'd1: begin
        c.t_src = T_ALU; c.alu_b = ALU_SUB_TWO; c.rf_we = 1'b1;
      end
      UA_M5 + 5'd2: c = CW_NOP;
      UA_M5 + 5'd3: c.t_src = T_MEM;
      UA_M5 + 5'd4: c.ea_src = EA_T;
      UA_M5 + 5'd5: begin
        c.val_src = VAL_MEM; c.seq = SEQ_DONE;
      end
      // indexed: offset word at pc, pc steps, then base register added
      UA_M6: begin
        c.t_src = T_REG; c.reg_sel = SEL_PC;
      end
      UA_M6 + 5'd1: begin
        c.reg_sel = SEL_PC; c.alu_b = ALU_ADD_TWO; c.rf_we = 1'b1;
      end
      UA_M6 + 5'd2: c.t_src = T_MEM;
      UA_M6 + 5'd3: begin
        c.t_src = T_ALU; c.alu_b = ALU_ADD_REG;
      end
      UA_M6 + 5'd4: c.ea_src = EA_T;
      UA_M6 + 5'd5: begin
        c.val_src = VAL_MEM; c.seq = SEQ_DONE;
      end
      // unsupported mode
      UA_M7: begin
        c.ea_src = EA_ZERO; c.val_src = VAL_ZERO; c.status = 1'b1; c.seq = SEQ_DONE;
      end
      default: begin
        c.ea_src = EA_ZERO; c.status = 1'b1; c.seq = SEQ_DONE;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- sv/pof_mem.sv -----
// byte-addressed memory in even and odd banks with one word read port
module pof_mem (
  input  logic        clk,
  input  logic        we,
  input  logic [15:0] waddr,
  input  logic [7:0]  wdata,
  input  logic [15:0] raddr,
  output logic [15:0] rdata
);

  logic [7:0] bank_even [pof_pkg::MEM_BYTES/2];
  logic [7:0] bank_odd  [pof_pkg::MEM_BYTES/2];

  logic [pof_pkg::MEM_AW-1:0]  wa;
  logic [pof_pkg::MEM_AW-1:0]  ra;
  logic [pof_pkg::MEM_AW-1:0]  ra_inc;
  logic [pof_pkg::BANK_AW-1:0] even_idx;
  logic [7:0]                  even_q;
  logic [7:0]                  odd_q;
  logic                        odd_start;

  // addresses wrap at the memory size
  assign wa       = waddr[pof_pkg::MEM_AW-1:0];
  assign ra       = raddr[pof_pkg::MEM_AW-1:0];
  assign ra_inc   = ra + {{(pof_pkg::MEM_AW-1){1'b0}}, 1'b1};
  assign even_idx = ra[0] ? ra_inc[pof_pkg::MEM_AW-1:1] : ra[pof_pkg::MEM_AW-1:1];

  // byte write
  always_ff @(posedge clk) begin
    if (we && !wa[0]) begin
      bank_even[wa[pof_pkg::MEM_AW-1:1]] <= wdata;
    end
    if (we && wa[0]) begin
      bank_odd[wa[pof_pkg::MEM_AW-1:1]] <= wdata;
    end
  end

  // registered read of both bytes of the word
  always_ff @(posedge clk) begin
    even_q    <= bank_even[even_idx];
    odd_q     <= bank_odd[ra[pof_pkg::MEM_AW-1:1]];
    odd_start <= ra[0];
  end

  // little-endian word: low byte at the address
  assign rdata = odd_start ? {even_q, odd_q} : {odd_q, even_q};

endmodule

// ----- sv/pof_seq.sv -----
// microprogram sequencer: step counter, dispatch on mode and control store
module pof_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            adv,
  input  logic [2:0]      mode,
  output logic            busy,
  output pof_pkg::ctrl_t  ctrl
);

  logic [pof_pkg::UPC_W-1:0] upc;

  assign ctrl = pof_pkg::ucode(upc);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= pof_pkg::UA_DISPATCH;
    end else if (start) begin
      busy <= 1'b1;
      upc  <= pof_pkg::UA_DISPATCH;
    end else if (busy && adv) begin
      unique case (ctrl.seq)
        pof_pkg::SEQ_NEXT:     upc <= upc + {{(pof_pkg::UPC_W-1){1'b0}}, 1'b1};
        pof_pkg::SEQ_DISPATCH: upc <= pof_pkg::ucode_entry(mode);
        pof_pkg::SEQ_DONE:     busy <= 1'b0;
        default:               busy <= 1'b0;
      endcase
    end
  end

endmodule

// ----- sv/pdp11_operand_fetch_top.sv -----
// operand fetch unit: register file, datapath and result register
// time from accept to result depends on the mode and is set by the microprogram length
// one resolve in flight; next word accepted the cycle after the final step
// register and memory writes take effect at accept
// reset zeroes the register file and clears busy and out_valid; memory contents are undefined until written
module pdp11_operand_fetch_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [2:0]  mode,
  input  logic [2:0]  reg_index,
  input  logic        byte_op,
  input  logic [15:0] address,
  input  logic [15:0] data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] operand_address,
  output logic [15:0] operand_value,
  output logic        status
);

  logic [15:0]    regfile [8];
  logic [2:0]     mode_l;
  logic [2:0]     r_l;
  logic           b_l;
  logic [15:0]    t;
  logic [15:0]    ea;
  logic [15:0]    mem_word;
  logic           busy;
  logic           accept;
  logic           start;
  logic           adv;
  logic           done;
  logic           step_one;
  logic [15:0]    step;
  logic [2:0]     sel_idx;
  logic [15:0]    rf_rd;
  logic [15:0]    alu_out;
  logic [15:0]    ea_next;
  logic [15:0]    val_new;
  logic           rd_byte;
  pof_pkg::ctrl_t ctrl;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign start    = accept && (opcode == pof_pkg::OP_RESOLVE);
  assign done     = busy && (ctrl.seq == pof_pkg::SEQ_DONE);
  assign adv      = !(done && out_valid && !out_ready);

  pof_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .adv   (adv),
    .mode  (mode_l),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  pof_mem u_mem (
    .clk   (clk),
    .we    (accept && (opcode == pof_pkg::OP_WRITE_MEM)),
    .waddr (address),
    .wdata (data[7:0]),
    .raddr (t),
    .rdata (mem_word)
  );

  // step size: bytes move by one except on stack pointer and pc
  assign step_one = b_l && (r_l < pof_pkg::REG_SP);
  assign step     = step_one ? 16'd1 : 16'd2;
  assign sel_idx  = (ctrl.reg_sel == pof_pkg::SEL_PC) ? pof_pkg::REG_PC : r_l;
  assign rf_rd    = regfile[sel_idx];

  // adder
  always_comb begin
    unique case (ctrl.alu_b)
      pof_pkg::ALU_ADD_STEP: alu_out = t + step;
      pof_pkg::ALU_SUB_STEP: alu_out = t - step;
      pof_pkg::ALU_ADD_TWO:  alu_out = t + 16'd2;
      pof_pkg::ALU_SUB_TWO:  alu_out = t - 16'd2;
      pof_pkg::ALU_ADD_REG:  alu_out = t + rf_rd;
      default:               alu_out = t;
    endcase
  end

  // effective address and result value
  assign rd_byte = ctrl.byte_by_step ? step_one : b_l;

  always_comb begin
    unique case (ctrl.ea_src)
      pof_pkg::EA_HOLD: ea_next = ea;
      pof_pkg::EA_T:    ea_next = t;
      pof_pkg::EA_RIDX: ea_next = {13'd0, r_l};
      pof_pkg::EA_ZERO: ea_next = 16'd0;
      default:          ea_next = ea;
    endcase
  end

  always_comb begin
    unique case (ctrl.val_src)
      pof_pkg::VAL_MEM: val_new = rd_byte ? {8'd0, mem_word[7:0]} : mem_word;
      pof_pkg::VAL_REG: val_new = b_l ? {8'd0, rf_rd[7:0]} : rf_rd;
      default:          val_new = 16'd0;
    endcase
  end

  // request fields held for the sequence
  always_ff @(posedge clk) begin
    if (start) begin
      mode_l <= mode;
      r_l    <= reg_index;
      b_l    <= byte_op;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (busy && adv) begin
      unique case (ctrl.t_src)
        pof_pkg::T_HOLD: t <= t;
        pof_pkg::T_REG:  t <= rf_rd;
        pof_pkg::T_ALU:  t <= alu_out;
        pof_pkg::T_MEM:  t <= mem_word;
        default:         t <= t;
      endcase
      ea <= ea_next;
    end
  end

  // register file: direct writes at accept, microcode writes while busy
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        regfile[i] <= 16'd0;
      end
    end else if (accept && (opcode == pof_pkg::OP_WRITE_REG)) begin
      regfile[reg_index] <= data;
    end else if (busy && adv && ctrl.rf_we) begin
      regfile[sel_idx] <= alu_out;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && adv) begin
      operand_address <= ea_next;
      operand_value   <= val_new;
      status          <= ctrl.status;
    end
  end

  // a resolve request always starts the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("sequencer did not start on resolve word");

  // the final step hands a result to the output and frees the unit
  a_done_result: assert property (@(posedge clk) disable iff (rst)
    done && adv |=> !busy && out_valid)
    else $error("final step did not produce a result");

  // an unsupported mode reports zero address and value
  a_unsupported_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> operand_address == 16'd0 && operand_value == 16'd0)
    else $error("unsupported result carries nonzero fields");

  // a register write lands in the addressed register
  a_reg_write: assert property (@(posedge clk) disable iff (rst)
    accept && opcode == pof_pkg::OP_WRITE_REG |=>
      regfile[$past(reg_index)] == $past(data))
    else $error("register write lost");

endmodule

// ----- bench/tb_pdp11_operand_fetch_top.sv -----
// self-checking testbench for the operand fetch unit: shadow state and random traffic
`timescale 1ns / 100ps

// addressing modes of the operand specifier
typedef enum logic [2:0] {
  AM_REG,
  AM_DEFERRED,
  AM_AUTOINC,
  AM_AUTOINC_DEF,
  AM_AUTODEC,
  AM_AUTODEC_DEF,
  AM_INDEXED,
  AM_UNSUPPORTED
} addr_mode_t;

// request code the block ignores
localparam logic [1:0] OP_UNUSED = 2'd3;

// one resolved operand
typedef struct packed {
  logic [15:0] addr;
  logic [15:0] value;
  logic        status;
} operand_t;

// shadow copy of the register file and memory, plus the operands still owed
class operand_resolver;
  logic [15:0] regs [8];
  bit [7:0]    mem_image [pof_pkg::MEM_BYTES];
  bit          written [pof_pkg::MEM_BYTES];
  operand_t    pending_operands [$];
  int          failures;

  function new();
    foreach (regs[i]) regs[i] = 16'd0;
    failures = 0;
  endfunction

  function int unsigned slot(logic [15:0] a);
    return int'(a) % pof_pkg::MEM_BYTES;
  endfunction

  // little-endian word, second byte wraps at the top of memory
  function logic [15:0] rd_word(logic [15:0] a);
    logic [15:0] nxt;
    nxt = a + 16'd1;
    return {mem_image[slot(nxt)], mem_image[slot(a)]};
  endfunction

  function logic [15:0] fetch(logic [15:0] a, logic bytewise);
    return bytewise ? {8'd0, mem_image[slot(a)]} : rd_word(a);
  endfunction

  // apply one accepted word and queue the operand it yields
  function void apply_word(logic [1:0] op, logic [2:0] m, logic [2:0] r, logic b,
                           logic [15:0] a, logic [15:0] d);
    operand_t    res;
    logic [15:0] step;
    logic [15:0] ofs;
    res  = '0;
    step = (b && r < pof_pkg::REG_SP) ? 16'd1 : 16'd2;
    case (op)
      pof_pkg::OP_WRITE_REG: regs[r] = d;
      pof_pkg::OP_WRITE_MEM: begin
        mem_image[slot(a)] = d[7:0];
        written[slot(a)]   = 1'b1;
      end
      pof_pkg::OP_RESOLVE: begin
        case (m)
          AM_REG: begin
            res.addr  = {13'd0, r};
            res.value = b ? {8'd0, regs[r][7:0]} : regs[r];
          end
          AM_DEFERRED: begin
            res.addr  = regs[r];
            res.value = fetch(res.addr, b);
          end
          AM_AUTOINC: begin
            res.addr  = regs[r];
            res.value = fetch(res.addr, step == 16'd1);
            regs[r]   = regs[r] + step;
          end
          AM_AUTOINC_DEF: begin
            res.addr  = rd_word(regs[r]);
            res.value = fetch(res.addr, b);
            regs[r]   = regs[r] + 16'd2;
          end
          AM_AUTODEC: begin
            regs[r]   = regs[r] - step;
            res.addr  = regs[r];
            res.value = fetch(res.addr, step == 16'd1);
          end
          AM_AUTODEC_DEF: begin
            regs[r]   = regs[r] - 16'd2;
            res.addr  = rd_word(regs[r]);
            res.value = fetch(res.addr, b);
          end
          AM_INDEXED: begin
            ofs                   = rd_word(regs[pof_pkg::REG_PC]);
            regs[pof_pkg::REG_PC] = regs[pof_pkg::REG_PC] + 16'd2;
            res.addr              = regs[r] + ofs;
            res.value             = fetch(res.addr, b);
          end
          default: res.status = 1'b1;
        endcase
        pending_operands.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // compare one operand leaving the block with the oldest one owed
  function void compare_operand(logic [15:0] addr, logic [15:0] value, logic st);
    operand_t want;
    if (pending_operands.size() == 0) begin
      $error("operand with none owed: operand_address %h operand_value %h status %b",
             addr, value, st);
      failures++;
      return;
    end
    want = pending_operands.pop_front();
    if (addr !== want.addr) begin
      $error("operand_address: expected %h, actual %h", want.addr, addr);
      failures++;
    end
    if (value !== want.value) begin
      $error("operand_value: expected %h, actual %h", want.value, value);
      failures++;
    end
    if (st !== want.status) begin
      $error("status: expected %b, actual %b", want.status, st);
      failures++;
    end
  endfunction
endclass

module tb_pdp11_operand_fetch_top;

  localparam int ITEM_TARGET = 1250;
  localparam int CALM_AFTER  = 1100;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [2:0]  mode = '0;
  logic [2:0]  reg_index = '0;
  logic        byte_op = 1'b0;
  logic [15:0] address = '0;
  logic [15:0] data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] operand_address;
  logic [15:0] operand_value;
  logic        status;

  operand_resolver mirror = new();
  bit calm = 1'b0;
  int words_sent = 0;
  int hold_cnt = 0;
  int cycle_count = 0;

  pdp11_operand_fetch_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .mode(mode),
    .reg_index(reg_index),
    .byte_op(byte_op),
    .address(address),
    .data(data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .operand_address(operand_address),
    .operand_value(operand_value),
    .status(status)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pdp11_operand_fetch_top regression: fail");
      $finish;
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (out_ready && $urandom_range(0, 24) == 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // check every accepted operand
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      mirror.compare_operand(operand_address, operand_value, status);
  end

  // present one word, hold it until accepted, then update the shadow state
  task automatic send(input logic [1:0] op, input logic [2:0] m, input logic [2:0] r,
                      input logic b, input logic [15:0] a, input logic [15:0] d);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    mode      <= m;
    reg_index <= r;
    byte_op   <= b;
    address   <= a;
    data      <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.apply_word(op, m, r, b, a, d);
    if (op != OP_UNUSED) words_sent++;
    if (words_sent >= CALM_AFTER) calm <= 1'b1;
  endtask

  task automatic load_reg(input logic [2:0] r, input logic [15:0] v);
    send(pof_pkg::OP_WRITE_REG, 3'($urandom), r, 1'($urandom), 16'($urandom), v);
  endtask

  task automatic noise_word();
    send(OP_UNUSED, 3'($urandom), 3'($urandom), 1'($urandom), 16'($urandom),
         16'($urandom));
  endtask

  // make sure a byte about to be read has been written
  task automatic fill_byte(input logic [15:0] a);
    if (!mirror.written[mirror.slot(a)])
      send(pof_pkg::OP_WRITE_MEM, 3'($urandom), 3'($urandom), 1'($urandom), a,
           16'($urandom));
  endtask

  task automatic fill_operand(input logic [15:0] a, input logic bytewise);
    logic [15:0] nxt;
    nxt = a + 16'd1;
    fill_byte(a);
    if (!bytewise) fill_byte(nxt);
  endtask

  // write whatever memory the resolve will read, then issue it
  task automatic resolve(input logic [2:0] m, input logic [2:0] r, input logic b);
    logic [15:0] step;
    logic [15:0] ptr;
    logic [15:0] ea;
    step = (b && r < pof_pkg::REG_SP) ? 16'd1 : 16'd2;
    case (m)
      AM_DEFERRED: fill_operand(mirror.regs[r], b);
      AM_AUTOINC: fill_operand(mirror.regs[r], step == 16'd1);
      AM_AUTOINC_DEF: begin
        fill_operand(mirror.regs[r], 1'b0);
        fill_operand(mirror.rd_word(mirror.regs[r]), b);
      end
      AM_AUTODEC: begin
        ptr = mirror.regs[r] - step;
        fill_operand(ptr, step == 16'd1);
      end
      AM_AUTODEC_DEF: begin
        ptr = mirror.regs[r] - 16'd2;
        fill_operand(ptr, 1'b0);
        fill_operand(mirror.rd_word(ptr), b);
      end
      AM_INDEXED: begin
        fill_operand(mirror.regs[pof_pkg::REG_PC], 1'b0);
        // the program counter has already stepped when it is the base
        ptr = (r == pof_pkg::REG_PC) ? mirror.regs[pof_pkg::REG_PC] + 16'd2
                                     : mirror.regs[r];
        ea  = ptr + mirror.rd_word(mirror.regs[pof_pkg::REG_PC]);
        fill_operand(ea, b);
      end
      default: ;
    endcase
    send(pof_pkg::OP_RESOLVE, m, r, b, 16'($urandom), 16'($urandom));
  endtask

  // pointer values clustered near the ends and in a few windows
  function automatic logic [15:0] pick_pointer();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'hFFF0 | 16'($urandom_range(0, 15));
      2: return 16'($urandom_range(0, 15));
      3: return 16'h4000 + 16'($urandom_range(0, 63));
      default: return 16'h8000 + 16'($urandom_range(0, 127));
    endcase
  endfunction

  // stimulus
  initial begin : stim
    int         pick;
    logic [2:0] r;
    logic [2:0] m;
    logic       b;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: register mode on a cleared and a full register, byte and word
    resolve(AM_REG, 3'd0, 1'b0);
    load_reg(3'd0, 16'hFFFF);
    resolve(AM_REG, 3'd0, 1'b1);
    resolve(AM_REG, 3'd0, 1'b0);
    // unsupported mode and an ignored request code
    resolve(AM_UNSUPPORTED, 3'd3, 1'b1);
    noise_word();
    // word read at the top address wraps to zero
    load_reg(3'd1, 16'hFFFF);
    resolve(AM_DEFERRED, 3'd1, 1'b0);
    // byte step of one on a general register, two on the stack pointer
    resolve(AM_AUTOINC, 3'd2, 1'b1);
    resolve(AM_AUTOINC, pof_pkg::REG_SP, 1'b1);
    // autodecrement from zero wraps
    resolve(AM_AUTODEC, 3'd4, 1'b1);
    resolve(AM_AUTOINC_DEF, 3'd1, 1'b0);
    resolve(AM_AUTODEC_DEF, pof_pkg::REG_PC, 1'b1);
    // indexed off the program counter itself and off another register
    resolve(AM_INDEXED, pof_pkg::REG_PC, 1'b0);
    resolve(AM_INDEXED, 3'd3, 1'b1);

    // random: mostly resolves, some preceded by a register load
    while (words_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        noise_word();
      end else if (pick < 14) begin
        load_reg(3'($urandom), pick_pointer());
      end else if (pick < 20) begin
        send(pof_pkg::OP_WRITE_MEM, 3'($urandom), 3'($urandom), 1'($urandom),
             pick_pointer(), 16'($urandom));
      end else begin
        r = 3'($urandom);
        m = 3'($urandom);
        b = 1'($urandom);
        if ($urandom_range(0, 2) == 0) load_reg(r, pick_pointer());
        resolve(m, r, b);
      end
    end
    in_valid <= 1'b0;

    // drain, then allow for the longest program
    while (mirror.pending_operands.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mirror.pending_operands.size() != 0) begin
      $error("%0d operands never arrived", mirror.pending_operands.size());
      mirror.failures++;
    end
    if (mirror.failures == 0) begin
      $display("pdp11_operand_fetch_top regression: pass");
    end else begin
      $display("pdp11_operand_fetch_top regression: fail");
    end
    $finish;
  end

endmodule
